FILE: hdl/ddao_pkg.sv
// shared types, constants and rounding helpers for the arc odometry block
package ddao_pkg;

  // cordic rotation count and derived widths
  localparam int ROTATION_STEPS = 16;
  localparam int STEP_W         = $clog2(ROTATION_STEPS + 1);
  localparam int ANG_W          = 34;

  // serial multiplier and divider widths
  localparam int MUL_AW = 50;
  localparam int MUL_BW = 34;
  localparam int MUL_PW = MUL_AW + MUL_BW;
  localparam int DIV_NW = 49;
  localparam int DIV_DW = 33;

  // angle constants, radians in Q29, gain in Q30
  localparam logic [DIV_DW-1:0]       TWO_PI_Q29      = 33'd3373259426;
  localparam logic signed [ANG_W-1:0] PI_Q29          = 34'sd1686629713;
  localparam logic signed [ANG_W-1:0] HALF_PI_Q29     = 34'sd843314857;
  localparam logic signed [ANG_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032875;

  // arctangent of 2^-i in Q29
  localparam logic [28:0] ATAN_Q29 [32] = '{
    29'd421657428, 29'd248918915, 29'd131521918, 29'd66762579, 29'd33510843,
    29'd16771758, 29'd8387925, 29'd4194219, 29'd2097141, 29'd1048575,
    29'd524288, 29'd262144, 29'd131072, 29'd65536, 29'd32768, 29'd16384,
    29'd8192, 29'd4096, 29'd2048, 29'd1024, 29'd512, 29'd256, 29'd128,
    29'd64, 29'd32, 29'd16, 29'd8, 29'd4, 29'd2, 29'd1, 29'd1, 29'd0
  };

  // register indexes
  localparam logic REG_DPD = 1'b0;
  localparam logic REG_LAG = 1'b1;

  typedef logic signed [MUL_PW-1:0] prod_t;

  typedef struct packed {
    logic               cmd;
    logic signed [31:0] left_angle;
    logic signed [31:0] right_angle;
    logic signed [31:0] heading_in;
    logic signed [31:0] new_x;
    logic signed [31:0] new_y;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] pose_x;
    logic signed [31:0] pose_y;
    logic signed [31:0] pose_heading;
  } out_item_t;

  // add half an lsb, then floor shift
  function automatic prod_t rnd_shr(prod_t v, int unsigned n);
    return (v + (prod_t'(1) <<< (n - 1))) >>> n;
  endfunction

  // clamp to the 32-bit signed range
  function automatic logic signed [31:0] sat32(prod_t v);
    if (v > prod_t'(32'sh7fffffff)) begin
      return 32'sh7fffffff;
    end else if (v < prod_t'(32'sh80000000)) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

endpackage

FILE: hdl/ddao_mul.sv
// bit-serial signed multiplier, one multiplier bit per cycle
module ddao_mul import ddao_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic signed [MUL_AW-1:0] a_i,
  input  logic signed [MUL_BW-1:0] b_i,
  output logic                     done_o,
  output prod_t                    p_o
);

  localparam int CNT_W = $clog2(MUL_BW);

  logic signed [MUL_AW-1:0] a_q;
  logic signed [MUL_AW+1:0] hi_q, addend, sum;
  logic [MUL_BW-1:0]        lo_q;
  logic [CNT_W-1:0]         cnt_q;
  logic                     busy_q, done_q, last;

  // add or, for the sign bit of b, subtract the multiplicand
  assign last   = cnt_q == CNT_W'(MUL_BW - 1);
  assign addend = lo_q[0] ? (MUL_AW+2)'(a_q) : '0;
  assign sum    = last ? hi_q - addend : hi_q + addend;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q    <= '0;
      hi_q   <= '0;
      lo_q   <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        a_q    <= a_i;
        hi_q   <= '0;
        lo_q   <= b_i;
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        hi_q  <= sum >>> 1;
        lo_q  <= {sum[0], lo_q[MUL_BW-1:1]};
        cnt_q <= cnt_q + 1'b1;
        if (last) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign p_o    = prod_t'({hi_q, lo_q});

endmodule

FILE: hdl/ddao_div.sv
// restoring unsigned divider, one quotient bit per cycle
module ddao_div import ddao_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DIV_NW-1:0] n_i,
  input  logic [DIV_DW-1:0] d_i,
  output logic              done_o,
  output logic [DIV_NW-1:0] q_o,
  output logic [DIV_DW-1:0] r_o
);

  localparam int CNT_W = $clog2(DIV_NW);

  logic [DIV_NW-1:0] q_q;
  logic [DIV_DW:0]   r_q, t, dx;
  logic [DIV_DW-1:0] d_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              busy_q, done_q, ge, last;

  // shift in the next dividend bit and try a subtract
  assign t    = {r_q[DIV_DW-1:0], q_q[DIV_NW-1]};
  assign dx   = {1'b0, d_q};
  assign ge   = t >= dx;
  assign last = cnt_q == CNT_W'(DIV_NW - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_q    <= '0;
      r_q    <= '0;
      d_q    <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        q_q    <= n_i;
        r_q    <= '0;
        d_q    <= d_i;
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        r_q   <= ge ? t - dx : t;
        q_q   <= {q_q[DIV_NW-2:0], ge};
        cnt_q <= cnt_q + 1'b1;
        if (last) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign q_o    = q_q;
  assign r_o    = r_q[DIV_DW-1:0];

endmodule

FILE: hdl/ddao_cordic.sv
// iterative cordic rotation giving sine and cosine, one step per cycle
module ddao_cordic import ddao_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [ANG_W-1:0] angle_i,
  output logic                    done_o,
  output logic signed [ANG_W-1:0] sin_o,
  output logic signed [ANG_W-1:0] cos_o
);

  logic signed [ANG_W-1:0] x_q, y_q, z_q, sx, sy, at, z0;
  logic [STEP_W-1:0]       i_q;
  logic                    flip_q, flip0, busy_q, done_q, last;

  // fold the angle into the right half plane
  always_comb begin
    z0    = angle_i;
    flip0 = 1'b0;
    if (angle_i > HALF_PI_Q29) begin
      z0    = angle_i - PI_Q29;
      flip0 = 1'b1;
    end else if (angle_i < -HALF_PI_Q29) begin
      z0    = angle_i + PI_Q29;
      flip0 = 1'b1;
    end
  end

  assign sx   = x_q >>> i_q;
  assign sy   = y_q >>> i_q;
  assign at   = signed'(ANG_W'(ATAN_Q29[5'(i_q)]));
  assign last = i_q == STEP_W'(ROTATION_STEPS - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q    <= '0;
      y_q    <= '0;
      z_q    <= '0;
      i_q    <= '0;
      flip_q <= 1'b0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        x_q    <= CORDIC_GAIN_Q30;
        y_q    <= '0;
        z_q    <= z0;
        flip_q <= flip0;
        i_q    <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        // rotate toward zero residual angle
        if (z_q >= 0) begin
          x_q <= x_q - sy;
          y_q <= y_q + sx;
          z_q <= z_q - at;
        end else begin
          x_q <= x_q + sy;
          y_q <= y_q - sx;
          z_q <= z_q + at;
        end
        i_q <= i_q + 1'b1;
        if (last) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign sin_o  = flip_q ? -y_q : y_q;
  assign cos_o  = flip_q ? -x_q : x_q;

endmodule

FILE: hdl/differential_drive_arc_odometry_top.sv
// top level of the arc odometry block: sequencer, pose state and ports
//
// One item is worked on at a time. A set-pose beat and the first sample after
// reset go straight to the done state, which loads the output register. The
// time a sample takes is set by the bit-serial multiplier (six products with
// no heading change, nine with one), the bit-serial divider (used for each
// angle reduction and for the chord factor) and the cordic (one run per
// sine/cosine pair). A new beat is taken while the last result still waits at
// the output.
module differential_drive_arc_odometry_top import ddao_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_D1, ST_D, ST_RH, ST_CH, ST_K, ST_CHORD, ST_LX, ST_LY,
    ST_RP, ST_CP, ST_X1, ST_X2, ST_Y1, ST_Y2, ST_DONE
  } state_e;

  state_e                  state_q;
  logic                    go_q;
  in_item_t                item_q;
  logic [23:0]             dpd_q;
  logic [16:0]             lag_q;
  logic                    primed_q;
  logic signed [31:0]      last_left_q, last_right_q, last_heading_q;
  logic signed [31:0]      acc_x_q, acc_y_q, acc_heading_q;
  logic signed [31:0]      dist_q, chord_q;
  logic signed [ANG_W-1:0] red_q, sh_q, ch_q, sp_q, cp_q, lx_q, ly_q;
  logic signed [MUL_AW-1:0] k_q;
  prod_t                   t_q;
  logic                    out_valid_q;
  out_item_t               out_q;

  logic                    accept, cfg_wr;
  logic signed [33:0]      s_w;
  logic signed [32:0]      dth_w;
  logic [32:0]             dth_mag;
  logic [ANG_W-1:0]        sh_mag;
  logic [31:0]             lh_mag;
  logic signed [31:0]      d_new;
  logic signed [ANG_W-1:0] red_new;
  logic [DIV_DW-1:0]       red_u;
  logic                    red_neg;

  logic                     mul_sel, div_sel, cor_sel;
  logic signed [MUL_AW-1:0] mul_a;
  logic signed [MUL_BW-1:0] mul_b;
  logic                     mul_done;
  prod_t                    mul_p;
  logic [DIV_NW-1:0]        div_n, div_q;
  logic [DIV_DW-1:0]        div_d, div_r;
  logic                     div_done;
  logic                     cor_done;
  logic signed [ANG_W-1:0]  cor_sin, cor_cos;

  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o = state_q != ST_IDLE;

  // encoder and heading deltas
  assign s_w   = 34'(item_q.left_angle) - 34'(last_left_q)
               + 34'(item_q.right_angle) - 34'(last_right_q);
  assign dth_w = 33'(item_q.heading_in) - 33'(last_heading_q);

  assign dth_mag = dth_w[32] ? 33'(-dth_w) : 33'(dth_w);
  assign sh_mag  = sh_q[ANG_W-1] ? ANG_W'(-sh_q) : ANG_W'(sh_q);
  assign lh_mag  = last_heading_q[31] ? 32'(-last_heading_q) : 32'(last_heading_q);

  assign d_new = sat32(rnd_shr(mul_p, 16));

  // floor modulo two pi, then into [-pi, pi)
  always_comb begin
    red_neg = (state_q == ST_RH) ? dth_w[32] : last_heading_q[31];
    red_u   = (red_neg && (div_r != '0)) ? TWO_PI_Q29 - div_r : div_r;
    red_new = signed'(ANG_W'(red_u));
    if (red_new >= PI_Q29) begin
      red_new = red_new - signed'(ANG_W'(TWO_PI_Q29));
    end
  end

  // operand selection for the shared units
  always_comb begin
    mul_sel = 1'b0;
    div_sel = 1'b0;
    cor_sel = 1'b0;
    mul_a   = '0;
    mul_b   = '0;
    div_n   = '0;
    div_d   = TWO_PI_Q29;
    case (state_q)
      ST_D1: begin
        mul_sel = 1'b1;
        mul_a   = MUL_AW'(s_w);
        mul_b   = signed'(MUL_BW'(dpd_q));
      end
      ST_D: begin
        mul_sel = 1'b1;
        mul_a   = MUL_AW'(dist_q);
        mul_b   = signed'(MUL_BW'(lag_q));
      end
      ST_RH: begin
        div_sel = 1'b1;
        div_n   = DIV_NW'(dth_mag) << 12;
      end
      ST_CH, ST_CP: begin
        cor_sel = 1'b1;
      end
      ST_K: begin
        div_sel = 1'b1;
        div_n   = DIV_NW'(sh_mag) << 17;
        div_d   = dth_mag;
      end
      ST_CHORD: begin
        mul_sel = 1'b1;
        mul_a   = k_q;
        mul_b   = MUL_BW'(dist_q);
      end
      ST_LX: begin
        mul_sel = 1'b1;
        mul_a   = MUL_AW'(sh_q);
        mul_b   = MUL_BW'(chord_q);
      end
      ST_LY: begin
        mul_sel = 1'b1;
        mul_a   = MUL_AW'(ch_q);
        mul_b   = MUL_BW'(chord_q);
      end
      ST_RP: begin
        div_sel = 1'b1;
        div_n   = DIV_NW'(lh_mag) << 13;
      end
      ST_X1: begin
        mul_sel = 1'b1;
        mul_a   = MUL_AW'(cp_q);
        mul_b   = MUL_BW'(lx_q);
      end
      ST_X2: begin
        mul_sel = 1'b1;
        mul_a   = MUL_AW'(sp_q);
        mul_b   = MUL_BW'(ly_q);
      end
      ST_Y1: begin
        mul_sel = 1'b1;
        mul_a   = MUL_AW'(sp_q);
        mul_b   = MUL_BW'(lx_q);
      end
      ST_Y2: begin
        mul_sel = 1'b1;
        mul_a   = MUL_AW'(cp_q);
        mul_b   = MUL_BW'(ly_q);
      end
      default: begin
      end
    endcase
  end

  ddao_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (go_q && mul_sel),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .p_o     (mul_p)
  );

  ddao_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (go_q && div_sel),
    .n_i     (div_n),
    .d_i     (div_d),
    .done_o  (div_done),
    .q_o     (div_q),
    .r_o     (div_r)
  );

  ddao_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (go_q && cor_sel),
    .angle_i (red_q),
    .done_o  (cor_done),
    .sin_o   (cor_sin),
    .cos_o   (cor_cos)
  );

  // configuration registers
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_LAG) ? 32'(lag_q) : 32'(dpd_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dpd_q <= 24'd1859;
      lag_q <= 17'd68157;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_DPD: dpd_q <= pwdata[23:0];
        REG_LAG: lag_q <= pwdata[16:0];
        default: begin
        end
      endcase
    end
  end

  // sequencer, pose state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      go_q           <= 1'b0;
      item_q         <= '0;
      primed_q       <= 1'b0;
      last_left_q    <= '0;
      last_right_q   <= '0;
      last_heading_q <= '0;
      acc_x_q        <= '0;
      acc_y_q        <= '0;
      acc_heading_q  <= '0;
      dist_q         <= '0;
      chord_q        <= '0;
      red_q          <= '0;
      sh_q           <= '0;
      ch_q           <= '0;
      sp_q           <= '0;
      cp_q           <= '0;
      lx_q           <= '0;
      ly_q           <= '0;
      k_q            <= '0;
      t_q            <= '0;
      out_valid_q    <= 1'b0;
      out_q          <= '0;
    end else begin
      go_q <= 1'b0;
      // the done state loads the output register itself
      if (out_valid_q && !out_stall_i && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            item_q <= in_data_i;
            if (in_data_i.cmd) begin
              acc_x_q        <= in_data_i.new_x;
              acc_y_q        <= in_data_i.new_y;
              acc_heading_q  <= in_data_i.heading_in;
              last_heading_q <= in_data_i.heading_in;
              state_q        <= ST_DONE;
            end else if (!primed_q) begin
              last_left_q    <= in_data_i.left_angle;
              last_right_q   <= in_data_i.right_angle;
              last_heading_q <= in_data_i.heading_in;
              primed_q       <= 1'b1;
              state_q        <= ST_DONE;
            end else begin
              state_q <= ST_D1;
              go_q    <= 1'b1;
            end
          end
        end
        ST_D1: begin
          if (mul_done) begin
            dist_q  <= sat32(rnd_shr(mul_p, 9));
            state_q <= ST_D;
            go_q    <= 1'b1;
          end
        end
        ST_D: begin
          if (mul_done) begin
            dist_q <= d_new;
            go_q   <= 1'b1;
            if (dth_w == '0) begin
              // straight ahead
              lx_q    <= '0;
              ly_q    <= ANG_W'(d_new);
              state_q <= ST_RP;
            end else begin
              state_q <= ST_RH;
            end
          end
        end
        ST_RH: begin
          if (div_done) begin
            red_q   <= red_new;
            state_q <= ST_CH;
            go_q    <= 1'b1;
          end
        end
        ST_CH: begin
          if (cor_done) begin
            sh_q    <= cor_sin;
            ch_q    <= cor_cos;
            state_q <= ST_K;
            go_q    <= 1'b1;
          end
        end
        ST_K: begin
          if (div_done) begin
            k_q <= (sh_q[ANG_W-1] ^ dth_w[32]) ? -MUL_AW'(div_q) : MUL_AW'(div_q);
            state_q <= ST_CHORD;
            go_q    <= 1'b1;
          end
        end
        ST_CHORD: begin
          if (mul_done) begin
            chord_q <= sat32(rnd_shr(mul_p, 30));
            state_q <= ST_LX;
            go_q    <= 1'b1;
          end
        end
        ST_LX: begin
          if (mul_done) begin
            lx_q    <= ANG_W'(rnd_shr(mul_p, 30));
            state_q <= ST_LY;
            go_q    <= 1'b1;
          end
        end
        ST_LY: begin
          if (mul_done) begin
            ly_q    <= ANG_W'(rnd_shr(mul_p, 30));
            state_q <= ST_RP;
            go_q    <= 1'b1;
          end
        end
        ST_RP: begin
          if (div_done) begin
            red_q   <= red_new;
            state_q <= ST_CP;
            go_q    <= 1'b1;
          end
        end
        ST_CP: begin
          if (cor_done) begin
            sp_q    <= cor_sin;
            cp_q    <= cor_cos;
            state_q <= ST_X1;
            go_q    <= 1'b1;
          end
        end
        ST_X1: begin
          if (mul_done) begin
            t_q     <= mul_p;
            state_q <= ST_X2;
            go_q    <= 1'b1;
          end
        end
        ST_X2: begin
          if (mul_done) begin
            // field x is the negated rotated x
            acc_x_q <= sat32(prod_t'(acc_x_q) - rnd_shr(t_q - mul_p, 30));
            state_q <= ST_Y1;
            go_q    <= 1'b1;
          end
        end
        ST_Y1: begin
          if (mul_done) begin
            t_q     <= mul_p;
            state_q <= ST_Y2;
            go_q    <= 1'b1;
          end
        end
        ST_Y2: begin
          if (mul_done) begin
            acc_y_q        <= sat32(prod_t'(acc_y_q) + rnd_shr(t_q + mul_p, 30));
            acc_heading_q  <= item_q.heading_in;
            last_left_q    <= item_q.left_angle;
            last_right_q   <= item_q.right_angle;
            last_heading_q <= item_q.heading_in;
            state_q        <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            out_q.pose_x       <= acc_x_q;
            out_q.pose_y       <= acc_y_q;
            out_q.pose_heading <= acc_heading_q;
            out_valid_q        <= 1'b1;
            state_q            <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: verif/tb_top.sv
// self-checking testbench for the arc odometry block, with its own pose predictor
module tb_top;
  import ddao_pkg::*;

  localparam string PASS_MSG = "end of test: clean";
  localparam int    MAX_SHOWN = 10;
  localparam longint TWO_PI = 64'sd3373259426;
  localparam longint PI_V = 64'sd1686629713;
  localparam longint HALF_PI = 64'sd843314857;
  localparam longint GAIN = 64'sd652032875;
  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  in_item_t    in_data_i;
  logic        out_valid_o;
  logic        out_stall_i;
  out_item_t   out_data_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  differential_drive_arc_odometry_top i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // predictor state and configuration
  longint    dist_scale, lag_scale;
  bit        have_history;
  longint    prev_left, prev_right, prev_head;
  longint    pos_x, pos_y, pos_head;
  out_item_t pose_q[$];

  int  mismatches = 0;
  bit  no_idle = 0;
  int  hold_off = 0;
  int  rx_wait = 0;

  // stimulus side tracking of the wheel positions
  longint gen_left, gen_right, gen_head;

  always begin
    clk_i = 1'b1; #1;
    clk_i = 1'b0; #1;
  end

  function automatic longint clamp32(longint v);
    if (v > S32_MAX) return S32_MAX;
    if (v < S32_MIN) return S32_MIN;
    return v;
  endfunction

  function automatic longint round_shr(longint v, int n);
    return (v + (longint'(1) <<< (n - 1))) >>> n;
  endfunction

  // cordic sine/cosine, angle in Q29, results in Q30
  task automatic sin_cos(input longint ang, output longint sn, output longint cs);
    longint r, x, y, nx;
    bit flip;
    r = ang % TWO_PI;
    x = GAIN;
    y = 0;
    flip = 0;
    if (r < 0) r += TWO_PI;
    if (r >= PI_V) r -= TWO_PI;
    if (r > HALF_PI) begin
      r -= PI_V; flip = 1;
    end else if (r < -HALF_PI) begin
      r += PI_V; flip = 1;
    end
    for (int i = 0; i < ROTATION_STEPS && i < 32; i++) begin
      if (r >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        r -= longint'(ATAN_Q29[i]);
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        r += longint'(ATAN_Q29[i]);
      end
      x = nx;
    end
    sn = flip ? -y : y;
    cs = flip ? -x : x;
  endtask

  // advance the pose for one accepted beat and queue the expected pose
  task automatic update_pose(input in_item_t it);
    longint lft, rgt, hd, s, d, dth, lx, ly, sh, ch, k, chord, sp, cp;
    out_item_t e;
    lft = longint'(it.left_angle);
    rgt = longint'(it.right_angle);
    hd = longint'(it.heading_in);
    if (it.cmd) begin
      pos_x = longint'(it.new_x);
      pos_y = longint'(it.new_y);
      pos_head = hd;
      prev_head = hd;
    end else if (!have_history) begin
      prev_left = lft;
      prev_right = rgt;
      prev_head = hd;
      have_history = 1;
    end else begin
      s = (lft - prev_left) + (rgt - prev_right);
      d = clamp32(round_shr(s * dist_scale, 9));
      d = clamp32(round_shr(d * lag_scale, 16));
      dth = hd - prev_head;
      if (dth == 0) begin
        lx = 0;
        ly = d;
      end else begin
        sin_cos(dth * 4096, sh, ch);
        k = (sh * 131072) / dth;
        chord = clamp32(round_shr(d * k, 30));
        lx = round_shr(chord * sh, 30);
        ly = round_shr(chord * ch, 30);
      end
      sin_cos(prev_head * 8192, sp, cp);
      pos_x = clamp32(pos_x - round_shr(lx * cp - ly * sp, 30));
      pos_y = clamp32(pos_y + round_shr(lx * sp + ly * cp, 30));
      pos_head = hd;
      prev_left = lft;
      prev_right = rgt;
      prev_head = hd;
    end
    e.pose_x = pos_x[31:0];
    e.pose_y = pos_y[31:0];
    e.pose_heading = pos_head[31:0];
    pose_q.push_back(e);
  endtask

  // send one beat, keeping valid high when no gap follows
  task automatic send_item(input in_item_t it);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    update_pose(it);
  endtask

  // register write over the apb port
  task automatic write_reg(input logic idx, input logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx == REG_DPD) dist_scale = longint'(val[23:0]);
    else lag_scale = longint'(val[16:0]);
  endtask

  // drop valid and wait for every expected pose to arrive
  task automatic drain;
    in_valid_i <= 1'b0;
    while (pose_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  function automatic in_item_t sample_item(int l, int r, int h);
    in_item_t it;
    it = '0;
    it.cmd = 1'b0;
    it.left_angle = l;
    it.right_angle = r;
    it.heading_in = h;
    it.new_x = $urandom;
    it.new_y = $urandom;
    return it;
  endfunction

  function automatic in_item_t pose_item(int x, int y, int h);
    in_item_t it;
    it = '0;
    it.cmd = 1'b1;
    it.left_angle = $urandom;
    it.right_angle = $urandom;
    it.heading_in = h;
    it.new_x = x;
    it.new_y = y;
    return it;
  endfunction

  // well-formed motion: small wheel deltas, and no, small or large heading change
  function automatic in_item_t motion_item();
    int mode;
    mode = $urandom_range(0, 9);
    gen_left += $signed($urandom_range(0, 8000)) - 4000;
    gen_right += $signed($urandom_range(0, 8000)) - 4000;
    if (mode < 3) gen_head += 0;
    else if (mode < 8) gen_head += $signed($urandom_range(0, 20000)) - 10000;
    else gen_head += $signed($urandom_range(0, 2000000)) - 1000000;
    return sample_item(int'(gen_left), int'(gen_right), int'(gen_head));
  endfunction

  function automatic in_item_t noise_item();
    logic [191:0] raw;
    in_item_t it;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    it = raw[$bits(in_item_t)-1:0];
    gen_left = longint'(it.left_angle);
    gen_right = longint'(it.right_angle);
    gen_head = longint'(it.heading_in);
    return it;
  endfunction

  // result checking and receiver stalls
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t e;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (pose_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("unexpected pose beat %p", out_data_o);
        end else begin
          e = pose_q.pop_front();
          if (out_data_o !== e) begin
            mismatches++;
            if (mismatches <= MAX_SHOWN)
              $display("pose mismatch: expected x %0d y %0d h %0d, got x %0d y %0d h %0d",
                       e.pose_x, e.pose_y, e.pose_heading, out_data_o.pose_x,
                       out_data_o.pose_y, out_data_o.pose_heading);
          end
        end
        rx_wait = no_idle ? 0 : $urandom_range(0, 3);
      end
      if (hold_off > 0) begin
        out_stall_i <= 1'b1;
        hold_off--;
      end else if (rx_wait > 0) begin
        out_stall_i <= 1'b1;
        rx_wait--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic test_directed;
    send_item(sample_item(100, 200, 0));
    send_item(sample_item(100, 200, 0));
    send_item(sample_item(25600, 25600, 0));
    send_item(sample_item(51200, 40000, 102944));
    send_item(sample_item(40000, 51200, -102944));
    send_item(sample_item(40001, 51200, -102943));
    send_item(pose_item(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff));
    send_item(sample_item(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff));
    send_item(sample_item(32'sh80000000, 32'sh80000000, 32'sh80000000));
    send_item(sample_item(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff));
    send_item(pose_item(0, 0, 0));
    send_item(sample_item(32'sh80000000, 32'sh7fffffff, 205887));
    send_item(sample_item(0, 0, -411775));
    send_item(pose_item(32'sh80000000, 32'sh7fffffff, 32'sh80000000));
    send_item(sample_item(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff));
    send_item(sample_item(-1, -1, -1));
    send_item(pose_item(-1, -1, -1));
    send_item(sample_item(0, 0, 0));
    gen_left = 0; gen_right = 0; gen_head = 0;
  endtask

  task automatic test_config_extremes;
    logic [31:0] dpd_set[4] = '{32'd0, 32'hffffff, 32'd1, 32'd1859};
    logic [31:0] lag_set[4] = '{32'd0, 32'h1ffff, 32'h1ffff, 32'd68157};
    for (int c = 0; c < 4; c++) begin
      drain();
      write_reg(REG_DPD, dpd_set[c] | ($urandom & 32'hff000000));
      write_reg(REG_LAG, lag_set[c] | ($urandom & 32'hfffe0000));
      for (int n = 0; n < 15; n++) send_item(n == 5 ? noise_item() : motion_item());
    end
  endtask

  task automatic test_random;
    for (int n = 0; n < 560; n++) begin
      if (n % 140 == 139) begin
        drain();
        write_reg(REG_DPD, $urandom_range(0, 4000));
        write_reg(REG_LAG, $urandom_range(0, 131071));
      end
      no_idle = (n >= 200 && n < 240);
      case ($urandom_range(0, 19))
        0, 1:    send_item(noise_item());
        2:       send_item(pose_item($urandom, $urandom, $urandom));
        default: send_item(motion_item());
      endcase
    end
    no_idle = 0;
  endtask

  task automatic test_backpressure;
    drain();
    hold_off = 3000;
    for (int n = 0; n < 20; n++) send_item(motion_item());
    drain();
    for (int n = 0; n < 20; n++) send_item(motion_item());
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    dist_scale = 1859;
    lag_scale = 68157;
    have_history = 0;
    prev_left = 0; prev_right = 0; prev_head = 0;
    pos_x = 0; pos_y = 0; pos_head = 0;
    gen_left = 0; gen_right = 0; gen_head = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_config_extremes();
    test_random();
    test_backpressure();
    drain();
    repeat (600) @(posedge clk_i);
    if (mismatches == 0 && pose_q.size() == 0) begin
      $display(PASS_MSG);
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // run limit
  initial begin
    #8000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
